/* rtl/permutation_unranker_assert.svh */
// ----------------------------------------------------------------------------
// Permutation unranker assertion macros
// Clocked, reset-gated property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANKER_ASSERT_SVH
`define PERMUTATION_UNRANKER_ASSERT_SVH

// same-cycle implication
`define PMU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define PMU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/pmu_pkg.sv */
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared widths, factorial table, FSM states and cell interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmu_pkg;

  localparam int MAX_SYMBOLS = 9;

  localparam int SIZE_W = 4;
  localparam int RANK_W = 19;
  localparam int SYM_W  = 4;
  localparam int FACT_W = 20;   // factorials saturate at all ones
  localparam int IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int PROD_W = FACT_W + IDX_W;

  localparam int IN_TDATA_W  = ((SIZE_W + RANK_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SYM_W + 7) / 8) * 8;

  // m! for every m a 4-bit size field can hold, saturated above 2^20-1
  localparam logic [FACT_W-1:0] FACT_TAB [16] = '{
    20'd1,      20'd1,      20'd2,      20'd6,
    20'd24,     20'd120,    20'd720,    20'd5040,
    20'd40320,  20'd362880, 20'hFFFFF,  20'hFFFFF,
    20'hFFFFF,  20'hFFFFF,  20'hFFFFF,  20'hFFFFF
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [SIZE_W-1:0] set_size;
    logic [SIZE_W-1:0] pos;
    logic [RANK_W-1:0] rank;
    logic [FACT_W-1:0] fact;
  } cell_ctl_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [RANK_W-1:0] mult;
  } cell_sel_t;

endpackage

/* rtl/pmu_cell.sv */
// ----------------------------------------------------------------------------
// pmu_cell
// One slot of the unused-symbol list: digit compare, pick and left shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmu_cell (
  input  logic                     clk,
  input  logic [pmu_pkg::IDX_W-1:0] cell_idx,
  input  pmu_pkg::cell_ctl_t       ctl,
  input  logic [pmu_pkg::SYM_W-1:0] nbr_sym,
  input  logic                     nbr_ge,
  output logic [pmu_pkg::SYM_W-1:0] sym_q,
  output logic                     ge,
  output pmu_pkg::cell_sel_t       sel
);
  import pmu_pkg::*;

  logic [SYM_W-1:0]  sym_r;
  logic [SYM_W-1:0]  sym_nxt;
  logic [PROD_W-1:0] mult;
  logic              active;
  logic              picked;

  // idx * (pos-1)!, the rank threshold for this slot
  assign mult   = PROD_W'(cell_idx) * PROD_W'(ctl.fact);
  assign active = int'(cell_idx) < int'(ctl.pos);
  assign ge     = active && ({{(PROD_W-RANK_W){1'b0}}, ctl.rank} >= mult);
  // thermometer edge: digit equals this slot
  assign picked = ge && !nbr_ge;

  assign sel.sym  = picked ? sym_r : '0;
  assign sel.mult = picked ? mult[RANK_W-1:0] : '0;
  assign sym_q    = sym_r;

  always_comb begin
    sym_nxt = sym_r;
    if (ctl.load) begin
      sym_nxt = (int'(cell_idx) < int'(ctl.set_size)) ? SYM_W'(int'(cell_idx) + 1) : '0;
    end else if (ctl.shift && !nbr_ge) begin
      sym_nxt = nbr_sym;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

endmodule

/* rtl/permutation_unranker.sv */
// ----------------------------------------------------------------------------
// permutation_unranker
// Factoradic unranking: streams the k-th lexicographic permutation of 1..n.
// ----------------------------------------------------------------------------
// On accept the cell row, position and rank load, or ST_ERR is entered for a bad
// rank or size; the first ST_RUN step then writes the output register. Symbols
//   follow one per cycle while the output register takes them; new requests wait for ST_IDLE.
// The cell row advances one position per cycle, stalled by the output register.
// Reset (rst_n low, synchronous): idle, output empty, rank and position cleared.
`timescale 1ns / 1ps

module permutation_unranker (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [3:0] set_size, [22:4] rank, [23] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pmu_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [3:0] symbol, [7:4] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pmu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // out_tuser: [0] rank_error
  output logic                           out_tuser
);
  import pmu_pkg::*;

  // request fields
  logic [SIZE_W-1:0] in_size;
  logic [RANK_W-1:0] in_rank;
  logic              in_bad;
  logic              in_fire;

  assign in_size = in_tdata[SIZE_W-1:0];
  assign in_rank = in_tdata[SIZE_W+RANK_W-1:SIZE_W];
  assign in_fire = in_tvalid && in_tready;

  // zero size, oversize, zero rank or rank beyond n!
  assign in_bad = (in_size == '0) || (int'(in_size) > MAX_SYMBOLS) || (in_rank == '0) ||
                  ({{(FACT_W-RANK_W){1'b0}}, in_rank} > FACT_TAB[in_size]);

  // control
  state_t state_r, state_nxt;
  logic   slot_free;
  logic   load;
  logic   step;
  logic   emit_err;

  logic [SIZE_W-1:0] pos_r,  pos_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r,   out_sym_nxt;
  logic             out_last_r,  out_last_nxt;
  logic             out_err_r,   out_err_nxt;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = in_bad ? ST_ERR : ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free && (pos_r == SIZE_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    step      = 1'b0;
    emit_err  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        load      = in_fire && !in_bad;
      end
      ST_RUN:  step     = slot_free;
      ST_ERR:  emit_err = slot_free;
      default: ;
    endcase
  end

  // cell row
  cell_ctl_t        ctl;
  logic [SYM_W-1:0] sym_chain [MAX_SYMBOLS];
  logic             ge_chain  [MAX_SYMBOLS];
  cell_sel_t        sel_chain [MAX_SYMBOLS];
  cell_sel_t        sel_any;

  always_comb begin
    ctl.load     = load;
    ctl.shift    = step;
    ctl.set_size = in_size;
    ctl.pos      = pos_r;
    ctl.rank     = rank_r;
    ctl.fact     = FACT_TAB[pos_r - SIZE_W'(1)];  // (positions after this one)!
  end

  for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
    logic [SYM_W-1:0] nbr_sym;
    logic             nbr_ge;

    if (g == MAX_SYMBOLS - 1) begin : g_end
      assign nbr_sym = '0;     // vacated tail slot fills with zero
      assign nbr_ge  = 1'b0;
    end else begin : g_mid
      assign nbr_sym = sym_chain[g+1];
      assign nbr_ge  = ge_chain[g+1];
    end

    pmu_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (ctl),
      .nbr_sym  (nbr_sym),
      .nbr_ge   (nbr_ge),
      .sym_q    (sym_chain[g]),
      .ge       (ge_chain[g]),
      .sel      (sel_chain[g])
    );
  end

  // while pos_r is nonzero exactly one cell is picked; OR the row together
  always_comb begin
    sel_any = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sel_any = sel_any | sel_chain[i];
    end
  end

  // position and rank
  always_comb begin
    pos_nxt  = pos_r;
    rank_nxt = rank_r;
    if (load) begin
      pos_nxt  = in_size;
      rank_nxt = in_rank - RANK_W'(1);
    end else if (step) begin
      pos_nxt  = pos_r - SIZE_W'(1);
      rank_nxt = rank_r - sel_any.mult;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    priority if (step) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = sel_any.sym;
      out_last_nxt  = (pos_r == SIZE_W'(1));
      out_err_nxt   = 1'b0;
    end else if (emit_err) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = '0;
      out_last_nxt  = 1'b1;
      out_err_nxt   = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SYM_W){1'b0}}, out_sym_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // checks
`include "permutation_unranker_assert.svh"

  `PMU_ASSERT_IMPL(a_err_single, out_tvalid && out_tuser, out_tlast && (out_tdata == '0))
  `PMU_ASSERT_NEXT(a_accept_busy, in_fire, (state_r == ST_RUN) || (state_r == ST_ERR))
  `PMU_ASSERT_IMPL(a_run_pos, state_r == ST_RUN, pos_r != '0)
  `PMU_ASSERT_NEXT(a_last_idle, step && (pos_r == SIZE_W'(1)), state_r == ST_IDLE && out_tlast)

endmodule

/* sim/permutation_unranker_checker.sv */
// ----------------------------------------------------------------------------
// permutation_unranker_checker
// Watches both streams, unranks every accepted request and compares symbols, last and error flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_unranker_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // in_tdata: [3:0] set_size, [22:4] rank, [23] zero
  input  logic [pmu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [3:0] symbol, [7:4] zero
  input  logic [pmu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  // out_tuser: [0] rank_error
  input  logic                            out_tuser,
  output int                              error_count,
  output int                              symbols_owed
);

  import pmu_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
    logic             rank_error;
  } symbol_beat_t;

  symbol_beat_t beat_queue[$];
  int           fails = 0;
  int           owed  = 0;

  assign error_count  = fails;
  assign symbols_owed = owed;

  function automatic longint unsigned factorial(input int m);
    longint unsigned f = 1;
    for (int i = 2; i <= m; i++) f *= i;
    return f;
  endfunction

  // Lexicographic unranking of 1..n; queues one beat per symbol, or one error beat for a bad request.
  function automatic void unrank_into_queue(input logic [SIZE_W-1:0] n,
                                            input logic [RANK_W-1:0] k);
    logic [SYM_W-1:0] pool [MAX_SYMBOLS];
    longint unsigned  left_rank, f, digit;
    int               count, idx;
    symbol_beat_t     b;
    if (n == 0 || n > MAX_SYMBOLS || k == 0 || k > factorial(n)) begin
      b.symbol     = '0;
      b.is_last    = 1'b1;
      b.rank_error = 1'b1;
      beat_queue   = {beat_queue, b};
      return;
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) pool[i] = (i < n) ? SYM_W'(i + 1) : '0;
    left_rank = k - 1;
    count     = n;
    for (int pos = n; pos > 0; pos--) begin
      f     = factorial(pos - 1);
      digit = left_rank / f;
      // index saturates to the last unused entry
      idx   = (digit >= longint'(count)) ? count - 1 : int'(digit);
      b.symbol     = pool[idx];
      b.is_last    = (pos == 1);
      b.rank_error = 1'b0;
      for (int j = idx; j + 1 < count; j++) pool[j] = pool[j + 1];
      count--;
      pool[count] = '0;
      left_rank   = left_rank % f;
      beat_queue  = {beat_queue, b};
    end
  endfunction

  always @(posedge clk) begin
    symbol_beat_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.symbol     = out_tdata[SYM_W-1:0];
        got.is_last    = out_tlast;
        got.rank_error = out_tuser;
        if (beat_queue.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, got symbol %0d last %0b err %0b",
                   $time, got.symbol, got.is_last, got.rank_error);
        end else begin
          want = beat_queue.pop_front();
          if (got.symbol !== want.symbol || got.is_last !== want.is_last ||
              got.rank_error !== want.rank_error) begin
            fails++;
            $display("%0t: expected symbol %0d last %0b err %0b, got symbol %0d last %0b err %0b",
                     $time, want.symbol, want.is_last, want.rank_error,
                     got.symbol, got.is_last, got.rank_error);
          end
        end
      end
      if (in_tvalid && in_tready)
        unrank_into_queue(in_tdata[SIZE_W-1:0], in_tdata[SIZE_W +: RANK_W]);
    end
    owed <= beat_queue.size();
  end

endmodule

/* sim/tb_permutation_unranker.sv */
// ----------------------------------------------------------------------------
// tb_permutation_unranker
// Directed and random requests with random stalls on both streams; the
// checker predicts every permutation and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_permutation_unranker;

  import pmu_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;
  localparam int TAIL_CYCLES  = 20;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   quiet_tail = 1'b0;
  int                     error_count;
  int                     symbols_owed;
  int                     cycle_count = 0;

  always #2 clk = ~clk;

  permutation_unranker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  permutation_unranker_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .error_count  (error_count),
    .symbols_owed (symbols_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("permutation_unranker: mismatch");
      $finish;
    end
  end

  // receiver: ready and stall bursts, always ready in the tail
  initial begin : sink
    int len;
    bit stall;
    forever begin
      stall = !quiet_tail && ($urandom_range(0, 2) == 0);
      len   = $urandom_range(1, 12);
      out_tready <= !stall;
      repeat (len) @(posedge clk);
    end
  end

  // valid stays high straight into the next request when there is no gap
  task automatic send_request(input logic [SIZE_W-1:0] n, input logic [RANK_W-1:0] k);
    int gap;
    gap = (!quiet_tail && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({k, n});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (symbols_owed != 0) @(posedge clk);
  endtask

  // mostly valid ranks; the rest zero, just above n!, wild, or bad size
  task automatic send_random_request;
    logic [SIZE_W-1:0] n;
    logic [RANK_W-1:0] k;
    int                pick;
    pick = $urandom_range(0, 19);
    n    = SIZE_W'($urandom_range(1, MAX_SYMBOLS));
    if (pick < 15)
      k = RANK_W'($urandom_range(1, FACT_TAB[n]));
    else if (pick == 15)
      k = $urandom_range(0, 1) ? RANK_W'(FACT_TAB[n]) : RANK_W'(1);
    else if (pick == 16)
      k = '0;
    else if (pick == 17)
      k = RANK_W'(FACT_TAB[n] + 1 + $urandom_range(0, 3));
    else if (pick == 18) begin
      n = SIZE_W'($urandom());
      k = RANK_W'($urandom());
    end else begin
      n = $urandom_range(0, 1) ? SIZE_W'(0) : SIZE_W'($urandom_range(MAX_SYMBOLS + 1, 15));
      k = RANK_W'($urandom());
    end
    send_request(n, k);
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sets of 1 to 8 symbols: both ends of the rank range, just past them, and mid ranks
    send_request(4'd1, 19'd1);
    send_request(4'd1, 19'd0);
    send_request(4'd1, 19'd2);
    send_request(4'd2, 19'd1);
    send_request(4'd2, 19'd2);
    for (int r = 1; r <= 6; r++) send_request(4'd3, RANK_W'(r));
    send_request(4'd4, 19'd24);
    send_request(4'd4, 19'd25);
    send_request(4'd5, 19'd61);
    send_request(4'd7, 19'd2520);
    send_request(4'd8, 19'd40320);
    // largest set: first, last, one beyond, all ones
    send_request(4'd9, 19'd1);
    send_request(4'd9, 19'd362880);
    send_request(4'd9, 19'd362881);
    send_request(4'd9, 19'h7FFFF);
    // sizes outside 1..MAX_SYMBOLS
    send_request(4'd0, 19'd1);
    send_request(4'd10, 19'd5);
    send_request(4'd15, 19'h7FFFF);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail <= 1'b1;
      send_random_request();
    end
    in_tvalid <= 1'b0;

    while (symbols_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && symbols_owed == 0)
      $display("permutation_unranker: match");
    else
      $display("permutation_unranker: mismatch");
    $finish;
  end

endmodule

/* permutation_unranker.f */
+incdir+rtl
rtl/pmu_pkg.sv
rtl/pmu_cell.sv
rtl/permutation_unranker.sv
sim/permutation_unranker_checker.sv
sim/tb_permutation_unranker.sv
